// ----- hw/rtl/i2p_pkg.sv -----
// ----------------------------------------------------------------------------
// i2p_pkg: shared constants and helpers for the infix to postfix converter
// Character codes, stack sizing and the symbol class checks.
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Operator stack sizing
    localparam int STACK_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
    localparam int SYM_W       = 8;

    // Character codes
    localparam logic [SYM_W-1:0] CH_END    = 8'd48;
    localparam logic [SYM_W-1:0] CH_UPPR_A = 8'd65;
    localparam logic [SYM_W-1:0] CH_UPPR_Z = 8'd90;
    localparam logic [SYM_W-1:0] CH_LOWR_A = 8'd97;
    localparam logic [SYM_W-1:0] CH_LOWR_Z = 8'd122;
    localparam logic [SYM_W-1:0] CH_MUL    = 8'd42;
    localparam logic [SYM_W-1:0] CH_ADD    = 8'd43;
    localparam logic [SYM_W-1:0] CH_SUB    = 8'd45;
    localparam logic [SYM_W-1:0] CH_DIV    = 8'd47;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'd41;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'd40;

    function automatic logic is_letter(input logic [SYM_W-1:0] c);
        return ((c >= CH_UPPR_A) && (c <= CH_UPPR_Z)) ||
               ((c >= CH_LOWR_A) && (c <= CH_LOWR_Z));
    endfunction

    function automatic logic is_muldiv(input logic [SYM_W-1:0] c);
        return (c == CH_MUL) || (c == CH_DIV);
    endfunction

    function automatic logic is_addsub(input logic [SYM_W-1:0] c);
        return (c == CH_ADD) || (c == CH_SUB);
    endfunction

    function automatic logic is_arith(input logic [SYM_W-1:0] c);
        return is_muldiv(c) || is_addsub(c);
    endfunction

endpackage

// ----- hw/rtl/i2p_ram.sv -----
// ----------------------------------------------------------------------------
// i2p_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/infix_to_postfix_converter_top.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: shunting-yard infix to postfix converter
// Takes one ASCII character per transaction and emits postfix characters,
// keeping the operator stack in a small synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_symbol) takes one character per
//   transaction. The output channel (o_valid/i_ready) returns one or more
//   results per character; o_last_of_run marks the final one, and a
//   character that emits nothing returns one result with o_has_symbol low.
//   Character '0' ends the expression: the stack is flushed and the sticky
//   overflow flag is cleared after its last result.
// Sequencing:
//   A letter goes straight to the output step. Any other character goes
//   through the push step first; an operator, ')' or '0' first pops the stack,
//   where each pop presents the address, then gets the registered RAM read.
//   The next character is taken once the last result sits in the output
//   register.
// Reset: i_rst_n (synchronous, active low) empties the stack and clears the
//   overflow flag; RAM contents are not cleared and need no clearing pass.
// Stalls: while i_ready is low the output register holds its result and a
//   pop that emits waits on it; input stays not ready until the run completes.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top
    import i2p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SYM_W-1:0] o_out_symbol,
    output logic             o_has_symbol,
    output logic             o_last_of_run,
    output logic             o_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_POP,
        S_FIN,
        S_LAST
    } t_state;

    t_state             r_state,      n_state;
    logic [SYM_W-1:0]   r_sym,        n_sym;
    logic [CNT_W-1:0]   r_count,      n_count;
    logic               r_ovf,        n_ovf;
    logic [EMIT_W-1:0]  r_emit_cnt,   n_emit_cnt;
    logic               r_pend_valid, n_pend_valid;
    logic [SYM_W-1:0]   r_pend_sym,   n_pend_sym;
    logic               r_o_valid,    n_o_valid;
    logic [SYM_W-1:0]   r_o_sym,      n_o_sym;
    logic               r_o_has,      n_o_has;
    logic               r_o_last,     n_o_last;
    logic               r_o_ovf,      n_o_ovf;

    logic               w_accept;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_count_m1;
    logic [IDX_W-1:0]   w_raddr;
    logic [SYM_W-1:0]   w_top;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic               w_take;
    logic               w_emit;
    logic               w_stall;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_raddr    = w_count_m1[IDX_W-1:0];
    assign w_waddr    = r_count[IDX_W-1:0];

    // Operator stack storage; read address always tracks the top entry
    i2p_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sym),
        .i_raddr (w_raddr),
        .o_rdata (w_top)
    );

    // Pop decision for the current top entry
    always_comb begin
        w_take = 1'b0;
        w_emit = 1'b0;
        if (r_sym == CH_END || r_sym == CH_RPAREN) begin
            w_take = 1'b1;
            w_emit = is_arith(w_top);
        end else if (is_addsub(r_sym)) begin
            w_take = is_arith(w_top);
            w_emit = w_take;
        end else begin
            w_take = is_muldiv(w_top);
            w_emit = w_take;
        end
        // Emissions past the per-item limit are dropped
        if (r_emit_cnt >= EMIT_W'(MAX_RESULTS)) begin
            w_emit = 1'b0;
        end
    end

    // A new emission must first move the pending one out
    assign w_stall = w_emit && r_pend_valid && !w_out_free;

    // Sequencer next-state logic
    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_emit_cnt   = r_emit_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_sym      = r_o_sym;
        n_o_has      = r_o_has;
        n_o_last     = r_o_last;
        n_o_ovf      = r_o_ovf;
        w_we         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sym      = i_symbol;
                    n_emit_cnt = '0;
                    if (is_letter(i_symbol)) begin
                        n_pend_valid = 1'b1;
                        n_pend_sym   = i_symbol;
                        n_emit_cnt   = EMIT_W'(1);
                        n_state      = S_LAST;
                    end else if (i_symbol == CH_END || i_symbol == CH_RPAREN ||
                                 is_arith(i_symbol)) begin
                        n_state = S_WAIT;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_WAIT: begin
                // RAM read of the top entry is in flight
                n_state = (r_count == '0) ? S_FIN : S_POP;
            end
            S_POP: begin
                if (!w_take) begin
                    n_state = S_FIN;
                end else if (!w_stall) begin
                    n_count = w_count_m1;
                    if (w_emit) begin
                        if (r_pend_valid) begin
                            n_o_valid = 1'b1;
                            n_o_sym   = r_pend_sym;
                            n_o_has   = 1'b1;
                            n_o_last  = 1'b0;
                            n_o_ovf   = r_ovf;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sym   = w_top;
                        n_emit_cnt   = r_emit_cnt + EMIT_W'(1);
                    end
                    if (r_sym == CH_RPAREN && w_top == CH_LPAREN) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_FIN: begin
                // Push the symbol unless it is an end or close character; a full stack sets the overflow flag
                if (r_sym != CH_END && r_sym != CH_RPAREN) begin
                    if (r_count < CNT_W'(STACK_DEPTH)) begin
                        w_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_LAST;
            end
            S_LAST: begin
                if (w_out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_sym      = r_pend_valid ? r_pend_sym : '0;
                    n_o_has      = r_pend_valid;
                    n_o_last     = 1'b1;
                    n_o_ovf      = r_ovf;
                    n_pend_valid = 1'b0;
                    if (r_sym == CH_END) begin
                        n_ovf = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_emit_cnt <= n_emit_cnt;
        r_pend_sym <= n_pend_sym;
        r_o_sym    <= n_o_sym;
        r_o_has    <= n_o_has;
        r_o_last   <= n_o_last;
        r_o_ovf    <= n_o_ovf;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_out_symbol  = r_o_sym;
    assign o_has_symbol  = r_o_has;
    assign o_last_of_run = r_o_last;
    assign o_overflow    = r_o_ovf;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input taken again before run completed");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending result left behind at end of run");

    a_end_clears_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST && w_out_free && r_sym == CH_END) |=> !r_ovf)
        else $error("overflow flag not cleared by end character");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the infix to postfix converter
// Feeds directed and random character streams through the valid/ready input
// channel, predicts every emitted postfix character with an independent
// operator stack, and checks each output transaction in order. Both sides
// idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import i2p_pkg::*;

    localparam int CHAR_TARGET = 330;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 60;
    localparam int DRAIN_WAIT  = 100;
    localparam int MAX_REPORTS = 10;

    typedef logic [SYM_W-1:0] char_t;

    // Character classes used by the stack predictor
    typedef enum logic [2:0] {
        SYM_END,
        SYM_LETTER,
        SYM_ADDSUB,
        SYM_MULDIV,
        SYM_CLOSE,
        SYM_OTHER
    } sym_kind_e;

    // One output transaction
    typedef struct packed {
        char_t ch;
        logic  has_ch;
        logic  end_of_run;
        logic  ovf;
    } postfix_char_t;

    // ------------------------------------------------------------------------
    // Operator stack tracker: predicts the emitted characters and checks them
    // ------------------------------------------------------------------------
    class postfix_tracker;
        char_t         op_stack [STACK_DEPTH];
        int            depth_used;
        bit            ovf_sticky;
        postfix_char_t run_q[$];
        postfix_char_t pending_chars[$];
        int            bad_count;

        function new();
            depth_used = 0;
            ovf_sticky = 1'b0;
            bad_count  = 0;
        endfunction

        function sym_kind_e classify(char_t c);
            if (c == CH_END)
                return SYM_END;
            if ((c >= CH_UPPR_A && c <= CH_UPPR_Z) || (c >= CH_LOWR_A && c <= CH_LOWR_Z))
                return SYM_LETTER;
            case (c)
                CH_ADD, CH_SUB: return SYM_ADDSUB;
                CH_MUL, CH_DIV: return SYM_MULDIV;
                CH_RPAREN:      return SYM_CLOSE;
                default:        return SYM_OTHER;
            endcase
        endfunction

        function bit is_op(char_t c);
            sym_kind_e k;
            k = classify(c);
            return (k == SYM_ADDSUB) || (k == SYM_MULDIV);
        endfunction

        function char_t stack_top();
            return op_stack[depth_used-1];
        endfunction

        function char_t pop_op();
            depth_used--;
            return op_stack[depth_used];
        endfunction

        // Full stack drops the push and sets the sticky flag
        function void push_op(char_t c);
            if (depth_used < STACK_DEPTH) begin
                op_stack[depth_used] = c;
                depth_used++;
            end else begin
                ovf_sticky = 1'b1;
            end
        endfunction

        // Emissions beyond the per-character limit are dropped
        function void emit(char_t c);
            if (run_q.size() < MAX_RESULTS)
                run_q.push_back('{ch: c, has_ch: 1'b1, end_of_run: 1'b0, ovf: 1'b0});
        endfunction

        // Accepted input transaction: work out its output run
        function void accept_char(char_t c);
            char_t top;
            bit    found_open;
            run_q.delete();
            found_open = 1'b0;
            case (classify(c))
                SYM_END: begin
                    while (depth_used > 0) begin
                        top = pop_op();
                        if (is_op(top))
                            emit(top);
                    end
                end
                SYM_LETTER: emit(c);
                SYM_ADDSUB: begin
                    while (depth_used > 0 && is_op(stack_top()))
                        emit(pop_op());
                    push_op(c);
                end
                SYM_MULDIV: begin
                    while (depth_used > 0 && classify(stack_top()) == SYM_MULDIV)
                        emit(pop_op());
                    push_op(c);
                end
                SYM_CLOSE: begin
                    while (depth_used > 0 && !found_open) begin
                        top = pop_op();
                        if (top == CH_LPAREN)
                            found_open = 1'b1;
                        else if (is_op(top))
                            emit(top);
                    end
                end
                default: push_op(c);
            endcase
            // Nothing emitted: a single empty result
            if (run_q.size() == 0)
                run_q.push_back('{ch: '0, has_ch: 1'b0, end_of_run: 1'b0, ovf: 1'b0});
            foreach (run_q[i])
                run_q[i].ovf = ovf_sticky;
            run_q[run_q.size()-1].end_of_run = 1'b1;
            // End character clears the flag after its run is reported
            if (classify(c) == SYM_END)
                ovf_sticky = 1'b0;
            foreach (run_q[i])
                pending_chars.push_back(run_q[i]);
        endfunction

        function void report(string msg);
            bad_count++;
            if (bad_count <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Accepted output transaction: compare with the oldest prediction
        function void check_emit(postfix_char_t got);
            postfix_char_t want;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected result ch=%02h has=%0b last=%0b ovf=%0b",
                                 got.ch, got.has_ch, got.end_of_run, got.ovf));
                return;
            end
            want = pending_chars.pop_front();
            if (got.ch !== want.ch)
                report($sformatf("out_symbol exp %02h got %02h", want.ch, got.ch));
            if (got.has_ch !== want.has_ch)
                report($sformatf("has_symbol exp %0b got %0b", want.has_ch, got.has_ch));
            if (got.end_of_run !== want.end_of_run)
                report($sformatf("last_of_run exp %0b got %0b",
                                 want.end_of_run, got.end_of_run));
            if (got.ovf !== want.ovf)
                report($sformatf("overflow exp %0b got %0b", want.ovf, got.ovf));
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic  i_clk    = 1'b0;
    logic  i_rst_n  = 1'b0;
    logic  i_valid  = 1'b0;
    logic  i_ready  = 1'b0;
    char_t i_symbol = '0;
    logic  o_ready;
    logic  o_valid;
    char_t o_out_symbol;
    logic  o_has_symbol;
    logic  o_last_of_run;
    logic  o_overflow;

    always #5 i_clk = ~i_clk;

    infix_to_postfix_converter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_symbol      (i_symbol),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_symbol  (o_out_symbol),
        .o_has_symbol  (o_has_symbol),
        .o_last_of_run (o_last_of_run),
        .o_overflow    (o_overflow)
    );

    postfix_tracker tracker = new();

    int    chars_sent = 0;
    int    tx_left    = 0;
    bit    tx_calm    = 1'b0;
    int    rx_left    = 0;
    bit    rx_calm    = 1'b0;
    char_t char_q[$];

    // Wait draw: stretches of back-to-back traffic alternate with idling
    function automatic int draw_wait(inout int stretch_left, inout bit calm);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(4, 30);
            calm         = ($urandom_range(0, 3) == 0);
        end
        stretch_left--;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // ------------------------------------------------------------------------
    // Character stream builders
    // ------------------------------------------------------------------------
    function automatic char_t random_letter();
        if ($urandom_range(0, 1) == 1)
            return char_t'($urandom_range(CH_UPPR_A, CH_UPPR_Z));
        return char_t'($urandom_range(CH_LOWR_A, CH_LOWR_Z));
    endfunction

    function automatic char_t random_op();
        case ($urandom_range(0, 3))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic void add_operand(int nest);
        if (nest < 3 && $urandom_range(0, 3) == 0) begin
            char_q.push_back(CH_LPAREN);
            add_expr(nest + 1);
            char_q.push_back(CH_RPAREN);
        end else begin
            char_q.push_back(random_letter());
        end
    endfunction

    // Well-formed infix expression with random content
    function automatic void add_expr(int nest);
        int terms;
        terms = $urandom_range(1, 4);
        add_operand(nest);
        for (int i = 1; i < terms; i++) begin
            char_q.push_back(random_op());
            add_operand(nest);
        end
    endfunction

    // Deep '(' op nesting, often past the stack depth, then partial unwind
    function automatic void add_deep_nest();
        int pairs;
        int closes;
        pairs  = $urandom_range(14, 22);
        closes = $urandom_range(0, pairs);
        for (int i = 0; i < pairs; i++) begin
            char_q.push_back(CH_LPAREN);
            char_q.push_back(random_op());
        end
        char_q.push_back(random_letter());
        for (int i = 0; i < closes; i++)
            char_q.push_back(CH_RPAREN);
        char_q.push_back(CH_END);
    endfunction

    // Broken sequences: tokens in any order, end character optional
    function automatic void add_broken();
        int len;
        len = $urandom_range(3, 12);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 4))
                0:       char_q.push_back(random_letter());
                1:       char_q.push_back(random_op());
                2:       char_q.push_back(CH_LPAREN);
                3:       char_q.push_back(CH_RPAREN);
                default: char_q.push_back(char_t'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            char_q.push_back(CH_END);
    endfunction

    function automatic void add_noise();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            char_q.push_back(char_t'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Input side driver
    // ------------------------------------------------------------------------
    task automatic send_char(input char_t c);
        int gap;
        gap = draw_wait(tx_left, tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= c;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        chars_sent++;
        tracker.accept_char(c);
    endtask

    task automatic send_queued();
        while (char_q.size() > 0)
            send_char(char_q.pop_front());
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready, one long hold-off to back the block up
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int results_seen;
        results_seen = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_wait(rx_left, rx_calm);
            if (results_seen == HOLD_AFTER)
                gap = LONG_HOLD;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            tracker.check_emit('{ch: o_out_symbol, has_ch: o_has_symbol,
                                 end_of_run: o_last_of_run, ovf: o_overflow});
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unmatched ')' and end on an empty stack, letter range
        // edges, every operator, a bracketed group, odd bytes pushed, flush
        char_q = '{CH_RPAREN, CH_END,
                   CH_UPPR_A, CH_ADD, CH_UPPR_Z, CH_MUL, CH_LOWR_A, CH_SUB,
                   CH_LOWR_Z, CH_DIV, CH_LPAREN, "b", CH_ADD, "c", CH_RPAREN,
                   CH_UPPR_A - 8'd1, CH_UPPR_Z + 8'd1, CH_LOWR_A - 8'd1,
                   CH_LOWR_Z + 8'd1, 8'hFF, 8'h00, CH_MUL, CH_END};
        send_queued();

        // Random: mostly well-formed expressions, some deep nesting, broken sequences and noise
        while (chars_sent < CHAR_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                add_expr(0);
                char_q.push_back(CH_END);
            end else if (pick < 70) begin
                add_deep_nest();
            end else if (pick < 85) begin
                add_broken();
            end else begin
                add_noise();
            end
            send_queued();
        end
        i_valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tracker.bad_count == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- infix_to_postfix_converter_top.f -----
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_ram.sv
hw/rtl/infix_to_postfix_converter_top.sv
dv/tb_top.sv
